// File: rtl/led_matrix_frame_refresh_assert.svh
// assertion macros used by the led matrix frame refresh checker
`ifndef LED_MATRIX_FRAME_REFRESH_ASSERT_SVH
`define LED_MATRIX_FRAME_REFRESH_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LMFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lmfr assertion failed");

// next-cycle implication, disabled while reset is low
`define LMFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lmfr assertion failed");

`endif

// File: rtl/lmfr_pkg.sv
// shared types and constants of the led matrix frame refresh block
package lmfr_pkg;

    // buffer geometry and field widths
    localparam int ROWS_DEF    = 8;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int OP_W        = 2;
    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 8;
    localparam int SETUP_WORDS = 5;

    // request codes
    typedef enum logic [1:0] {
        REQ_PIXEL   = 2'd0,
        REQ_ROW     = 2'd1,
        REQ_REFRESH = 2'd2,
        REQ_INIT    = 2'd3
    } t_req;

    // pixel operation codes, anything else toggles
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT  = 2'd2;

    // configuration reset values
    localparam logic [7:0] RST_DECODE_MODE = 8'd0;
    localparam logic [3:0] RST_INTENSITY   = 4'd1;
    localparam logic [2:0] RST_SCAN_LIMIT  = 3'd7;

    // driver chip register addresses
    localparam logic [ADDR_W-1:0] ADDR_DECODE    = 4'h9;
    localparam logic [ADDR_W-1:0] ADDR_INTENSITY = 4'hA;
    localparam logic [ADDR_W-1:0] ADDR_SCANLIMIT = 4'hB;
    localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN  = 4'hC;
    localparam logic [ADDR_W-1:0] ADDR_TEST      = 4'hF;

    // setup word positions within an init run
    localparam int WORD_DECODE    = 0;
    localparam int WORD_INTENSITY = 1;
    localparam int WORD_SCANLIMIT = 2;
    localparam int WORD_SHUTDOWN  = 3;
    localparam int WORD_TEST      = 4;

    // column 0 is the row byte's most significant bit
    localparam logic [DATA_W-1:0] COL0_MASK = 8'h80;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_REFRESH,
        ST_INIT
    } t_state;

endpackage

// File: rtl/led_matrix_frame_refresh.sv
// top level: frame buffer memory and word sequencer for an 8x8 led driver chip
//
// Requests enter on start while busy is low, with req_type, row, col,
// pixel_op and row_data sampled at that edge. Words leave on o_reg_addr,
// o_reg_data and o_last, each shown for one cycle while o_valid is high;
// the receiver takes every word and cannot stall.
// A row load writes the buffer memory at the accept edge.
// A pixel request reads its row at the accept edge and writes it back in the
// cycle after, since the read port of the buffer memory is registered.
// A refresh keeps busy high while it makes one memory read per row; the
// first row is read at the accept edge and passes the read data register
// and the output register; the rest follow one per cycle, the last one flagged.
// An init keeps busy high while it emits decode mode, intensity, scan limit,
// shutdown and display test words, then ROWS zeroed row words, one per cycle,
// without touching the buffer.
// Configuration writes on i_cfg_we take effect at once.
// Reset clears every buffer row (per-row valid bits), the sequencer and the
// configuration registers to their defaults.
module led_matrix_frame_refresh
    import lmfr_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_req_type,
    input  logic [ROW_W-1:0]     i_row,
    input  logic [COL_W-1:0]     i_col,
    input  logic [OP_W-1:0]      i_pixel_op,
    input  logic [DATA_W-1:0]    i_row_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [ADDR_W-1:0]    o_reg_addr,
    output logic [DATA_W-1:0]    o_reg_data,
    output logic                 o_last
);

    localparam int AW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int INIT_LEN  = SETUP_WORDS + ROWS;
    localparam int CNT_W     = $clog2(INIT_LEN);
    localparam logic [ROW_W:0]   ROW_LIM     = (ROW_W + 1)'(ROWS);
    localparam logic [CNT_W-1:0] REFR_LAST   = CNT_W'(ROWS - 1);
    localparam logic [CNT_W-1:0] INIT_LAST   = CNT_W'(INIT_LEN - 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [AW-1:0]     r_row;
    logic [COL_W-1:0]  r_col;
    logic [OP_W-1:0]   r_op;
    logic              accept;
    logic              row_ok;
    t_req              req;

    // configuration registers
    logic [7:0] r_decode_mode;
    logic [3:0] r_intensity;
    logic [2:0] r_scan_limit;

    // frame buffer memory and per-row valid bits
    logic [DATA_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]   r_row_vld;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_hit;
    logic [DATA_W-1:0] rd_row;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] bit_mask;

    // output register
    logic              r_valid, n_valid;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_last, n_last;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign req     = t_req'(i_req_type);
    assign row_ok  = ({1'b0, i_row} < ROW_LIM);
    assign rd_row  = r_rd_hit ? r_rd_data : '0;
    assign bit_mask = COL0_MASK >> r_col;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= RST_DECODE_MODE;
            r_intensity   <= RST_INTENSITY;
            r_scan_limit  <= RST_SCAN_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DECODE_MODE: r_decode_mode <= i_cfg_data[7:0];
                CFG_INTENSITY:   r_intensity   <= i_cfg_data[3:0];
                CFG_SCAN_LIMIT:  r_scan_limit  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // buffer memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // row valid bits, a row never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            r_rd_hit <= r_row_vld[rd_addr];
        end
    end

    // pixel request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= i_row[AW-1:0];
            r_col <= i_col;
            r_op  <= i_pixel_op;
        end
    end

    // sequencer state and word counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    case (req)
                        REQ_PIXEL:   n_state = row_ok ? ST_MODIFY : ST_IDLE;
                        REQ_REFRESH: n_state = ST_REFRESH;
                        REQ_INIT:    n_state = ST_INIT;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MODIFY: begin
                n_state = ST_IDLE;
            end
            ST_REFRESH: begin
                if (r_cnt == REFR_LAST) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_INIT: begin
                if (r_cnt == INIT_LAST) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // memory access and emitted words
    always_comb begin
        rd_addr = i_row[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = i_row[AW-1:0];
        wr_data = i_row_data;
        n_valid = 1'b0;
        n_addr  = r_addr;
        n_data  = r_data;
        n_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (req == REQ_REFRESH) begin
                    rd_addr = '0;
                end
                wr_en = accept && (req == REQ_ROW) && row_ok;
            end
            ST_MODIFY: begin
                wr_en   = 1'b1;
                wr_addr = r_row;
                case (r_op)
                    OP_CLEAR: wr_data = rd_row & ~bit_mask;
                    OP_SET:   wr_data = rd_row | bit_mask;
                    default:  wr_data = rd_row ^ bit_mask;
                endcase
            end
            ST_REFRESH: begin
                rd_addr = AW'(r_cnt + 1'b1);
                n_valid = 1'b1;
                n_addr  = ADDR_W'(r_cnt + 1'b1);
                n_data  = rd_row;
                n_last  = (r_cnt == REFR_LAST);
            end
            ST_INIT: begin
                n_valid = 1'b1;
                n_last  = (r_cnt == INIT_LAST);
                case (r_cnt)
                    CNT_W'(WORD_DECODE): begin
                        n_addr = ADDR_DECODE;
                        n_data = r_decode_mode;
                    end
                    CNT_W'(WORD_INTENSITY): begin
                        n_addr = ADDR_INTENSITY;
                        n_data = {4'd0, r_intensity};
                    end
                    CNT_W'(WORD_SCANLIMIT): begin
                        n_addr = ADDR_SCANLIMIT;
                        n_data = {5'd0, r_scan_limit};
                    end
                    CNT_W'(WORD_SHUTDOWN): begin
                        n_addr = ADDR_SHUTDOWN;
                        n_data = 8'd1;
                    end
                    CNT_W'(WORD_TEST): begin
                        n_addr = ADDR_TEST;
                        n_data = 8'd0;
                    end
                    default: begin
                        n_addr = ADDR_W'(r_cnt - CNT_W'(SETUP_WORDS) + 1'b1);
                        n_data = 8'd0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // output register, one word per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_addr <= n_addr;
        r_data <= n_data;
        r_last <= n_last;
    end

    assign o_valid    = r_valid;
    assign o_reg_addr = r_addr;
    assign o_reg_data = r_data;
    assign o_last     = r_valid && r_last;

endmodule

// File: rtl/lmfr_checker.sv
// port-level checker for the led matrix frame refresh block, bound to the top level
`include "led_matrix_frame_refresh_assert.svh"

module lmfr_checker
    import lmfr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [1:0]        i_req_type,
    input logic              o_valid,
    input logic [ADDR_W-1:0] o_reg_addr,
    input logic              o_last
);

    // a run of words has no gaps until its flagged word
    `LMFR_ASSERT_NXT(a_run_contiguous, i_clk, i_rst_n, o_valid && !o_last, o_valid)

    // nothing follows a flagged word in the next cycle
    `LMFR_ASSERT_NXT(a_gap_after_last, i_clk, i_rst_n, o_valid && o_last, !o_valid)

    // refresh and init transfers hold the block busy
    `LMFR_ASSERT_NXT(a_run_busy, i_clk, i_rst_n,
        start && !busy && (i_req_type == REQ_REFRESH || i_req_type == REQ_INIT), busy)

    // no valid word carries register address zero
    `LMFR_ASSERT_IMP(a_addr_nonzero, i_clk, i_rst_n, o_valid, o_reg_addr != '0)

endmodule

bind led_matrix_frame_refresh lmfr_checker u_lmfr_checker (.*);
